FILE: rtl/core/clcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_PUT    = 2'd1,
    OP_GOTO   = 2'd2,
    OP_CURSOR = 2'd3
  } op_t;

  // Control characters recognized by put character
  localparam logic [7:0] CH_FORM_FEED = 8'h0C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  // Controller command bytes
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_ROW2_HOME  = 8'hC0;
  localparam logic [7:0] CMD_CURSOR_L   = 8'h10;
  localparam logic [7:0] CMD_DISP_BLINK = 8'h0F;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_FUNC_SET   = 8'h20;

  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;
  localparam logic [7:0] ROW3_BASE = 8'h94;
  localparam logic [7:0] ROW4_BASE = 8'hD4;

  localparam logic [3:0] NIB_WAKE  = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;

  localparam int WAIT_W = 14;
  localparam logic [WAIT_W-1:0] BYTE_PRE_US  = 14'd60;
  localparam logic [WAIT_W-1:0] POWER_UP_US  = 14'd15000;
  localparam logic [WAIT_W-1:0] INIT_STEP_US = 14'd5000;
  localparam logic [WAIT_W-1:0] CLEAR_US     = 14'd2000;
  localparam logic [WAIT_W-1:0] NO_WAIT_US   = '0;

  localparam logic [1:0] LINE_MODE_RST = 2'd2;

  // Nibble sequencer step count
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd11;
  localparam logic [STEP_W-1:0] INIT_BYTE_STEP = 4'd4;

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One job: either the init run or a single byte
  typedef struct packed {
    logic              init;
    logic [7:0]        data;
    logic              rs;
    logic [WAIT_W-1:0] after_us;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/clcd_job_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module clcd_job_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire clcd_pkg::job_t    wr_data,
  input  wire logic              rd_en,
  output clcd_pkg::job_t         rd_data,
  output clcd_pkg::q_status_t    status
);
  import clcd_pkg::*;

  job_t           slot_r [QDEPTH];
  logic [QAW:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW:0]   rd_ptr_r, rd_ptr_nxt;

  assign status.empty = (wr_ptr_r == rd_ptr_r);
  assign status.full  = (wr_ptr_r[QAW] != rd_ptr_r[QAW]) &&
                        (wr_ptr_r[QAW-1:0] == rd_ptr_r[QAW-1:0]);
  assign rd_data      = slot_r[rd_ptr_r[QAW-1:0]];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en && !status.full) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (rd_en && !status.empty) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !status.full) begin
      slot_r[wr_ptr_r[QAW-1:0]] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/clcd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module clcd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [1:0]      cfg_wr_data,
  input  wire logic            push,
  input  wire logic [1:0]      in_op,
  input  wire logic [7:0]      in_char_code,
  input  wire logic [7:0]      in_column,
  input  wire logic [2:0]      in_row,
  input  wire logic            in_cursor_enable,
  input  wire clcd_pkg::q_status_t q_status,
  output logic                 full,
  output logic                 q_wr_en,
  output clcd_pkg::job_t       q_wr_data
);
  import clcd_pkg::*;

  logic [1:0] line_mode_r;
  logic [7:0] row_base;
  op_t        op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_mode_r <= LINE_MODE_RST;
    end else if (cfg_wr_en) begin
      line_mode_r <= cfg_wr_data;
    end
  end

  assign full    = q_status.full;
  assign q_wr_en = push && !q_status.full;
  assign op      = op_t'(in_op);

  always_comb begin
    unique case (in_row)
      3'd2:    row_base = ROW2_BASE;
      3'd3:    row_base = ROW3_BASE;
      3'd4:    row_base = ROW4_BASE;
      default: row_base = ROW1_BASE;
    endcase
  end

  // Classify the command into one queue job
  always_comb begin
    q_wr_data          = '0;
    q_wr_data.after_us = NO_WAIT_US;
    unique case (op)
      OP_INIT: begin
        q_wr_data.init = 1'b1;
        q_wr_data.data = CMD_FUNC_SET | {4'd0, line_mode_r, 2'd0};
      end
      OP_PUT: begin
        priority if (in_char_code == CH_FORM_FEED) begin
          q_wr_data.data     = CMD_CLEAR;
          q_wr_data.after_us = CLEAR_US;
        end else if (in_char_code == CH_NEWLINE) begin
          q_wr_data.data = CMD_ROW2_HOME;
        end else if (in_char_code == CH_BACKSPACE) begin
          q_wr_data.data = CMD_CURSOR_L;
        end else begin
          q_wr_data.data = in_char_code;
          q_wr_data.rs   = 1'b1;
        end
      end
      OP_GOTO: begin
        // one-based column: add minus one, wrap at 8 bits
        q_wr_data.data = row_base + in_column + 8'hFF;
      end
      OP_CURSOR: begin
        q_wr_data.data = in_cursor_enable ? CMD_DISP_BLINK : CMD_DISP_ON;
      end
      default: begin
        q_wr_data.data = CMD_DISP_ON;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/clcd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module clcd_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire clcd_pkg::job_t      job,
  input  wire clcd_pkg::q_status_t q_status,
  output logic                     q_rd_en,
  input  wire logic                pop,
  output logic                     empty,
  output logic [3:0]               out_nibble,
  output logic                     out_reg_select,
  output logic [13:0]              out_wait_before_us,
  output logic [13:0]              out_wait_after_us,
  output logic                     out_last
);
  import clcd_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              valid_r, valid_nxt;
  logic              emit, last_step;

  logic [3:0]        nib;
  logic              rs;
  logic [WAIT_W-1:0] before_us, after_us;
  logic [7:0]        cur_byte;
  logic [WAIT_W-1:0] byte_after;

  assign empty     = !valid_r;
  assign emit      = !q_status.empty && (!valid_r || pop);
  assign last_step = job.init ? (step_r == INIT_LAST_STEP) : step_r[0];
  assign q_rd_en   = emit && last_step;

  // Byte currently being split; init bytes follow the wake-up nibbles
  always_comb begin
    cur_byte   = job.data;
    byte_after = job.after_us;
    if (job.init) begin
      byte_after = INIT_STEP_US;
      unique case (step_r[2:1])
        2'd2:    cur_byte = job.data;
        2'd3:    cur_byte = CMD_DISP_ON;
        2'd0:    cur_byte = CMD_CLEAR;
        default: cur_byte = CMD_ENTRY_MODE;
      endcase
    end
  end

  always_comb begin
    if (job.init && (step_r < INIT_BYTE_STEP)) begin
      rs = 1'b0;
      unique case (step_r[1:0])
        2'd0: begin
          nib = NIB_WAKE; before_us = POWER_UP_US; after_us = INIT_STEP_US;
        end
        2'd1, 2'd2: begin
          nib = NIB_WAKE; before_us = NO_WAIT_US; after_us = INIT_STEP_US;
        end
        default: begin
          nib = NIB_4BIT; before_us = NO_WAIT_US; after_us = NO_WAIT_US;
        end
      endcase
    end else begin
      rs = job.init ? 1'b0 : job.rs;
      if (step_r[0]) begin
        nib = cur_byte[3:0]; before_us = NO_WAIT_US; after_us = byte_after;
      end else begin
        nib = cur_byte[7:4]; before_us = BYTE_PRE_US; after_us = NO_WAIT_US;
      end
    end
  end

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (pop && valid_r) begin
      valid_nxt = 1'b0;
    end
    if (emit) begin
      valid_nxt = 1'b1;
      step_nxt  = last_step ? '0 : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_nibble         <= nib;
      out_reg_select     <= rs;
      out_wait_before_us <= before_us;
      out_wait_after_us  <= after_us;
      out_last           <= last_step;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/char_lcd_4bit_command_serializer.sv
// Flow: an accepted command is written to the job queue; the nibble sequencer then
//   registers its first nibble in the output stage, then one per cycle while pop keeps
//   up; a byte command gives 2 nibbles, init 12; a four-job queue lets commands wait.
// Reset (rst_n low, synchronous): queue and output stage empty, line_mode back to 2.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_4bit_command_serializer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [7:0]  in_column,
  input  wire logic [2:0]  in_row,
  input  wire logic        in_cursor_enable,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       out_nibble,
  output logic             out_reg_select,
  output logic [13:0]      out_wait_before_us,
  output logic [13:0]      out_wait_after_us,
  output logic             out_last
);
  import clcd_pkg::*;

  job_t      q_wr_data, q_rd_data;
  logic      q_wr_en, q_rd_en;
  q_status_t q_status;

  clcd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .push             (push),
    .in_op            (in_op),
    .in_char_code     (in_char_code),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_cursor_enable (in_cursor_enable),
    .q_status         (q_status),
    .full             (full),
    .q_wr_en          (q_wr_en),
    .q_wr_data        (q_wr_data)
  );

  clcd_job_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  clcd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job                (q_rd_data),
    .q_status           (q_status),
    .q_rd_en            (q_rd_en),
    .pop                (pop),
    .empty              (empty),
    .out_nibble         (out_nibble),
    .out_reg_select     (out_reg_select),
    .out_wait_before_us (out_wait_before_us),
    .out_wait_after_us  (out_wait_after_us),
    .out_last           (out_last)
  );

  a_q_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("job queue full and empty at once");

  a_rd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd_en |-> !q_status.empty)
    else $error("job retired from an empty queue");

  a_retire_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd_en |=> (!empty && out_last))
    else $error("retired job did not leave a last nibble");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr_en && !q_rd_en && q_status.empty) |=> !q_status.empty)
    else $error("job written to queue was lost");

endmodule

`default_nettype wire
